// ===== rtl/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character constants and operator tables for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef logic [2:0] op_code_t;
  localparam op_code_t CODE_ADD    = 3'd0;
  localparam op_code_t CODE_SUB    = 3'd1;
  localparam op_code_t CODE_MUL    = 3'd2;
  localparam op_code_t CODE_DIV    = 3'd3;
  localparam op_code_t CODE_LPAREN = 3'd4;

  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNMATCHED = 2'd2;

  typedef logic [2:0] emit_sel_t;
  localparam emit_sel_t SEL_CHAR    = 3'd0;
  localparam emit_sel_t SEL_SPACE   = 3'd1;
  localparam emit_sel_t SEL_TOP     = 3'd2;
  localparam emit_sel_t SEL_ERR_OVF = 3'd3;
  localparam emit_sel_t SEL_ERR_RP  = 3'd4;

  typedef logic [1:0] prec_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_t sel;
    logic      push;
    logic      pop;
    logic      set_operand;
    logic      clr_operand;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_alnum;
    logic is_space;
    logic is_op;
    logic is_lp;
    logic is_rp;
    logic in_operand;
    logic count_zero;
    logic full;
    logic top_lp;
    logic top_ge;
    logic can_emit;
    logic pend_valid;
    logic out_free;
  } status_t;

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      CODE_ADD:    c = CH_PLUS;
      CODE_SUB:    c = CH_MINUS;
      CODE_MUL:    c = CH_STAR;
      CODE_DIV:    c = CH_SLASH;
      CODE_LPAREN: c = CH_LPAREN;
      default:     c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic prec_t code_prec(input op_code_t code);
    prec_t p;
    unique case (code)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic op_code_t op_code(input logic [7:0] c);
    op_code_t code;
    unique case (c)
      CH_MINUS: code = CODE_SUB;
      CH_STAR:  code = CODE_MUL;
      CH_SLASH: code = CODE_DIV;
      default:  code = CODE_ADD;
    endcase
    return code;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// ===== rtl/i2p_dp.sv =====
// ----------------------------------------------------------------------------
// i2p_dp
// Datapath: word register, operator stack, operand flag, pending result and
// output register.
// ----------------------------------------------------------------------------
module i2p_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  i2p_pkg::cmd_t      cmd,
  output i2p_pkg::status_t   status,
  input  logic               mode,
  input  logic [7:0]         in_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output i2p_pkg::err_t      error,
  output logic               last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic                 mode_q;
  logic [7:0]           char_q;
  i2p_pkg::op_code_t    stack [STACK_DEPTH];
  logic [CW-1:0]        count;
  logic                 in_operand;
  logic                 pend_valid;
  logic [7:0]           pend_char;
  i2p_pkg::err_t        pend_err;

  logic [AW-1:0]        top_idx;
  i2p_pkg::op_code_t    top_code;
  i2p_pkg::op_code_t    push_code;
  logic                 out_free;
  logic [7:0]           new_char;
  i2p_pkg::err_t        new_err;
  logic [CW-1:0]        count_m1;

  assign count_m1  = count - CW'(1);
  assign top_idx   = count_m1[AW-1:0];
  assign top_code  = (count == '0) ? i2p_pkg::CODE_ADD : stack[top_idx];
  assign out_free  = !out_valid || !out_stall;
  assign push_code = (char_q == i2p_pkg::CH_LPAREN) ? i2p_pkg::CODE_LPAREN
                                                    : i2p_pkg::op_code(char_q);

  always_comb begin
    status.is_end     = mode_q;
    status.is_alnum   = !mode_q && i2p_pkg::is_alnum(char_q);
    status.is_space   = !mode_q && (char_q == i2p_pkg::CH_SPACE);
    status.is_lp      = !mode_q && (char_q == i2p_pkg::CH_LPAREN);
    status.is_rp      = !mode_q && (char_q == i2p_pkg::CH_RPAREN);
    status.is_op      = !mode_q && (char_q == i2p_pkg::CH_PLUS ||
                                    char_q == i2p_pkg::CH_MINUS ||
                                    char_q == i2p_pkg::CH_STAR ||
                                    char_q == i2p_pkg::CH_SLASH);
    status.in_operand = in_operand;
    status.count_zero = (count == '0);
    status.full       = (count >= CW'(STACK_DEPTH));
    status.top_lp     = (top_code == i2p_pkg::CODE_LPAREN);
    status.top_ge     = i2p_pkg::code_prec(top_code) >=
                        i2p_pkg::code_prec(i2p_pkg::op_code(char_q));
    status.can_emit   = !pend_valid || out_free;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  always_comb begin
    new_char = i2p_pkg::CH_NUL;
    new_err  = i2p_pkg::ERR_NONE;
    unique case (cmd.sel)
      i2p_pkg::SEL_CHAR:    new_char = char_q;
      i2p_pkg::SEL_SPACE:   new_char = i2p_pkg::CH_SPACE;
      i2p_pkg::SEL_TOP:     new_char = i2p_pkg::code_char(top_code);
      i2p_pkg::SEL_ERR_OVF: new_err  = i2p_pkg::ERR_OVERFLOW;
      i2p_pkg::SEL_ERR_RP:  new_err  = i2p_pkg::ERR_UNMATCHED;
      default:              new_err  = i2p_pkg::ERR_NONE;
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      char_q <= in_char;
    end
    if (cmd.push) begin
      stack[count[AW-1:0]] <= push_code;
    end
    if (cmd.emit) begin
      pend_char <= new_char;
      pend_err  <= new_err;
    end
    if ((cmd.emit && pend_valid) || cmd.flush) begin
      out_char <= pend_char;
      error    <= pend_err;
      last     <= cmd.flush;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      in_operand <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count_m1;
      end
      if (cmd.set_operand) begin
        in_operand <= 1'b1;
      end else if (cmd.clr_operand) begin
        in_operand <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.emit && pend_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error != i2p_pkg::ERR_NONE) |-> (out_char == i2p_pkg::CH_NUL))
    else $error("error word carries a character");

  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && pend_valid) |=> out_valid)
    else $error("pending word lost");

endmodule

// ===== rtl/i2p_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2p_ctrl
// Controller: sequences the pushes, pops and emitted words of one input word.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2p_pkg::status_t status,
  output i2p_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LOOP  = 3'd2;
  localparam logic [2:0] S_POPSP = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = i2p_pkg::SEL_CHAR;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (status.is_alnum) begin
          if (status.can_emit) begin
            cmd.emit        = 1'b1;
            cmd.sel         = i2p_pkg::SEL_CHAR;
            cmd.set_operand = 1'b1;
            state_next      = S_FLUSH;
          end
        end else if (status.is_space) begin
          state_next = S_FLUSH;
        end else if (status.in_operand) begin
          if (status.can_emit) begin
            cmd.emit        = 1'b1;
            cmd.sel         = i2p_pkg::SEL_SPACE;
            cmd.clr_operand = 1'b1;
            state_next      = S_LOOP;
          end
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        priority if (status.is_end) begin
          if (status.count_zero) begin
            state_next = S_FLUSH;
          end else if (status.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.sel    = i2p_pkg::SEL_TOP;
            cmd.pop    = 1'b1;
            state_next = S_POPSP;
          end
        end else if (status.is_lp) begin
          if (!status.full) begin
            cmd.push   = 1'b1;
            state_next = S_FLUSH;
          end else if (status.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.sel    = i2p_pkg::SEL_ERR_OVF;
            state_next = S_FLUSH;
          end
        end else if (status.is_rp) begin
          priority if (!status.count_zero && !status.top_lp) begin
            if (status.can_emit) begin
              cmd.emit   = 1'b1;
              cmd.sel    = i2p_pkg::SEL_TOP;
              cmd.pop    = 1'b1;
              state_next = S_POPSP;
            end
          end else if (!status.count_zero) begin
            cmd.pop    = 1'b1;
            state_next = S_FLUSH;
          end else begin
            if (status.can_emit) begin
              cmd.emit   = 1'b1;
              cmd.sel    = i2p_pkg::SEL_ERR_RP;
              state_next = S_FLUSH;
            end
          end
        end else if (status.is_op) begin
          priority if (!status.count_zero && status.top_ge) begin
            if (status.can_emit) begin
              cmd.emit   = 1'b1;
              cmd.sel    = i2p_pkg::SEL_TOP;
              cmd.pop    = 1'b1;
              state_next = S_POPSP;
            end
          end else if (!status.full) begin
            cmd.push   = 1'b1;
            state_next = S_FLUSH;
          end else begin
            if (status.can_emit) begin
              cmd.emit   = 1'b1;
              cmd.sel    = i2p_pkg::SEL_ERR_OVF;
              state_next = S_FLUSH;
            end
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_POPSP: begin
        if (status.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.sel    = i2p_pkg::SEL_SPACE;
          state_next = S_LOOP;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !status.pend_valid)
    else $error("pending word left over between words");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.pop}))
    else $error("push and pop together");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (state == S_IDLE && !status.pend_valid))
    else $error("flush did not close the word");

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from infix characters to postfix characters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, mode, in_char): one infix character per
// word, mode=1 closes the expression. Output channel (out_valid/out_stall,
// out_char, error, last): postfix characters, last marks the final word
// caused by an input word; an error word carries out_char 0.
// One input word at a time: in_stall is high from acceptance until all of its
// words have left the pending register. From one acceptance to the next, an
// alphanumeric or a space passes through START and FLUSH; any other word
// goes through START, the stack step in LOOP and then FLUSH, with one POPSP
// after each popped operator, whether or not it closes an operand. The pop
// loop moves one output word a cycle, while the output does not stall,
// through the single pending register. Output stalls can hold any step that
// emits. The first output word passes the pending, then the output register.
// A stall on the output holds the output register; the controller waits
// with the next word pending, so nothing is lost.
// Reset (rst, synchronous) empties the stack, clears the operand flag and
// drops any output; stack entries are not cleared and need none.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          mode,
  input  logic [7:0]    in_char,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic [1:0]    error,
  output logic          last
);

  i2p_pkg::cmd_t    cmd;
  i2p_pkg::status_t status;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (mode),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .error     (error),
    .last      (last)
  );

endmodule

// ===== test/infix_to_postfix_checker.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_checker
// Watches both channels of the converter. Every accepted infix word is run
// through a shunting-yard model of its own; the postfix words it gives are
// queued and every accepted output word is compared field by field with
// the oldest one.
// ----------------------------------------------------------------------------
module infix_to_postfix_checker #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       mode,
  input  logic [7:0] in_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic [1:0] error,
  input  logic       last,
  output int         fail_count,
  output int         words_due
);

  typedef struct packed {
    logic [7:0]     ch;
    i2p_pkg::err_t  err;
    logic           last;
  } postfix_word_t;

  postfix_word_t        postfix_due[$];
  postfix_word_t        word_batch[$];
  i2p_pkg::op_code_t    op_stack[DEPTH];
  int                   depth_used;
  logic                 mid_operand;
  postfix_word_t        want;
  logic                 bad;

  function automatic logic alnum_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic int op_rank(input i2p_pkg::op_code_t code);
    case (code)
      i2p_pkg::CODE_ADD, i2p_pkg::CODE_SUB: return 1;
      i2p_pkg::CODE_MUL, i2p_pkg::CODE_DIV: return 2;
      default:                              return 0;
    endcase
  endfunction

  function automatic logic [7:0] op_symbol(input i2p_pkg::op_code_t code);
    case (code)
      i2p_pkg::CODE_ADD:    return i2p_pkg::CH_PLUS;
      i2p_pkg::CODE_SUB:    return i2p_pkg::CH_MINUS;
      i2p_pkg::CODE_MUL:    return i2p_pkg::CH_STAR;
      i2p_pkg::CODE_DIV:    return i2p_pkg::CH_SLASH;
      i2p_pkg::CODE_LPAREN: return i2p_pkg::CH_LPAREN;
      default:              return i2p_pkg::CH_NUL;
    endcase
  endfunction

  task automatic emit_word(input logic [7:0] c, input i2p_pkg::err_t e);
    postfix_word_t w;
    w.ch = c;
    w.err = e;
    w.last = 1'b0;
    word_batch.push_back(w);
  endtask

  task automatic pop_op();
    i2p_pkg::op_code_t code;
    code = op_stack[depth_used - 1];
    depth_used--;
    emit_word(op_symbol(code), i2p_pkg::ERR_NONE);
    emit_word(i2p_pkg::CH_SPACE, i2p_pkg::ERR_NONE);
  endtask

  task automatic push_op(input i2p_pkg::op_code_t code);
    if (depth_used >= DEPTH) begin
      emit_word(i2p_pkg::CH_NUL, i2p_pkg::ERR_OVERFLOW);
    end else begin
      op_stack[depth_used] = code;
      depth_used++;
    end
  endtask

  task automatic shunt_word(input logic m, input logic [7:0] c);
    postfix_word_t w;
    i2p_pkg::op_code_t code;
    int rank;
    word_batch.delete();
    if (m) begin
      if (mid_operand) emit_word(i2p_pkg::CH_SPACE, i2p_pkg::ERR_NONE);
      while (depth_used > 0) pop_op();
      mid_operand = 1'b0;
    end else if (alnum_char(c)) begin
      mid_operand = 1'b1;
      emit_word(c, i2p_pkg::ERR_NONE);
    end else if (c != i2p_pkg::CH_SPACE) begin
      // anything else closes an open operand, ignored characters included
      if (mid_operand) begin
        mid_operand = 1'b0;
        emit_word(i2p_pkg::CH_SPACE, i2p_pkg::ERR_NONE);
      end
      case (c)
        i2p_pkg::CH_LPAREN: push_op(i2p_pkg::CODE_LPAREN);
        i2p_pkg::CH_RPAREN: begin
          while (depth_used > 0 && op_stack[depth_used - 1] != i2p_pkg::CODE_LPAREN)
            pop_op();
          if (depth_used > 0) depth_used--;
          else emit_word(i2p_pkg::CH_NUL, i2p_pkg::ERR_UNMATCHED);
        end
        i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS, i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH: begin
          code = (c == i2p_pkg::CH_PLUS)  ? i2p_pkg::CODE_ADD :
                 (c == i2p_pkg::CH_MINUS) ? i2p_pkg::CODE_SUB :
                 (c == i2p_pkg::CH_STAR)  ? i2p_pkg::CODE_MUL : i2p_pkg::CODE_DIV;
          rank = op_rank(code);
          while (depth_used > 0 && op_rank(op_stack[depth_used - 1]) >= rank) pop_op();
          push_op(code);
        end
        default: ;
      endcase
    end
    foreach (word_batch[i]) begin
      w = word_batch[i];
      w.last = (i == word_batch.size() - 1);
      postfix_due.push_back(w);
    end
  endtask

  initial begin
    fail_count = 0;
    words_due = 0;
    depth_used = 0;
    mid_operand = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      depth_used = 0;
      mid_operand = 1'b0;
      postfix_due.delete();
    end else begin
      if (in_valid && !in_stall) shunt_word(mode, in_char);
      if (out_valid && !out_stall) begin
        if (postfix_due.size() == 0) begin
          $display("%0t: expected no word, got out_char %h error %0d last %b",
                   $time, out_char, error, last);
          fail_count++;
        end else begin
          want = postfix_due.pop_front();
          bad = 1'b0;
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
            bad = 1'b1;
          end
          if (error !== want.err) begin
            $display("%0t: error expected %0d got %0d", $time, want.err, error);
            bad = 1'b1;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, last);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    words_due = postfix_due.size();
  end

endmodule

// ===== test/infix_to_postfix_converter_tb.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Drives infix words into the converter: a directed opener, a deeply nested
// expression that overflows the stack, then random expressions with some
// noise and broken ones. Both sides idle at random and the output is held
// off once for a long stretch. The checker does the comparing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

  localparam int STACK_DEPTH = 16;
  localparam int ITEM_TARGET = 420;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic       m;
    logic [7:0] c;
  } infix_word_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       mode;
  logic [7:0] in_char;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic [1:0] error;
  logic       last;
  int         fail_count;
  int         words_due;

  infix_word_t infix_q[$];
  int          sent;
  int          cycle_count;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .in_char(in_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .error(error), .last(last)
  );

  infix_to_postfix_checker #(.DEPTH(STACK_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .in_char(in_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .error(error), .last(last),
    .fail_count(fail_count), .words_due(words_due)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic put(input logic m, input logic [7:0] c);
    infix_word_t w;
    w.m = m;
    w.c = c;
    infix_q.push_back(w);
  endtask

  task automatic put_operand();
    int n;
    int r;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) put(1'b0, i2p_pkg::CH_SPACE);
      if ($urandom_range(0, 40) == 0) put(1'b0, 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 61);
      if (r < 10) put(1'b0, 8'("0" + r));
      else if (r < 36) put(1'b0, 8'("A" + r - 10));
      else put(1'b0, 8'("a" + r - 36));
    end
  endtask

  task automatic put_expression(input int lead);
    int open;
    int terms;
    int target;
    logic want_operand;
    logic [7:0] ops[4];
    ops = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS, i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH};
    open = 0;
    terms = 0;
    target = $urandom_range(1, 6);
    want_operand = 1'b1;
    repeat (lead) begin
      put(1'b0, i2p_pkg::CH_LPAREN);
      open++;
    end
    forever begin
      if (want_operand) begin
        if (open < 5 && $urandom_range(0, 3) == 0) begin
          put(1'b0, i2p_pkg::CH_LPAREN);
          open++;
        end else begin
          put_operand();
          terms++;
          want_operand = 1'b0;
        end
      end else if (open > 0 && $urandom_range(0, 2) == 0) begin
        put(1'b0, i2p_pkg::CH_RPAREN);
        open--;
      end else if (terms >= target) begin
        break;
      end else begin
        if ($urandom_range(0, 3) == 0) put(1'b0, i2p_pkg::CH_SPACE);
        put(1'b0, ops[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) put(1'b0, i2p_pkg::CH_SPACE);
        want_operand = 1'b1;
      end
    end
    // now and then leave a '(' open for the end word to flush
    if ($urandom_range(0, 5) != 0) begin
      repeat (open) put(1'b0, i2p_pkg::CH_RPAREN);
    end
    case ($urandom_range(0, 9))
      0: put(1'b0, 8'($urandom_range(0, 255)));
      1: put(1'b0, i2p_pkg::CH_RPAREN);
      default: ;
    endcase
    // occasionally no end word, so the next expression runs on
    if ($urandom_range(0, 9) != 0) put(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_all();
    infix_word_t w;
    int gap;
    while (infix_q.size() > 0) begin
      w = infix_q.pop_front();
      gap = (sent % 60 < 15) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      mode = w.m;
      in_char = w.c;
      do @(posedge clk); while (in_stall);
      sent++;
      @(negedge clk);
    end
  endtask

  // output side, with one long hold-off so the input backs up
  initial begin
    int stall_len;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken == 90) stall_len = 600;
      else if (taken % 40 < 10) stall_len = 0;
      else stall_len = $urandom_range(0, 19);
      if (stall_len > 0) begin
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = 1'b0;
    in_char = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opener
    put(1'b0, "A");
    put(1'b0, i2p_pkg::CH_SPACE);
    put(1'b0, "z");
    put(1'b0, 8'hFF);
    put(1'b0, "0");
    put(1'b0, i2p_pkg::CH_PLUS);
    put(1'b0, "9");
    put(1'b0, i2p_pkg::CH_STAR);
    put(1'b0, i2p_pkg::CH_LPAREN);
    put(1'b0, "a");
    put(1'b0, i2p_pkg::CH_MINUS);
    put(1'b0, "Z");
    put(1'b0, i2p_pkg::CH_SLASH);
    put(1'b0, "b");
    put(1'b0, i2p_pkg::CH_RPAREN);
    put(1'b0, i2p_pkg::CH_RPAREN);
    put(1'b0, 8'h00);
    put(1'b0, i2p_pkg::CH_LPAREN);
    put(1'b0, "x");
    put(1'b1, 8'hFF);
    put(1'b0, i2p_pkg::CH_RPAREN);
    put(1'b1, 8'h00);
    send_all();

    // nesting past the stack depth
    put_expression(STACK_DEPTH + 2);
    send_all();

    while (sent < ITEM_TARGET) begin
      put_expression(($urandom_range(0, 19) == 0) ? $urandom_range(6, STACK_DEPTH + 2) : 0);
      send_all();
    end
    in_valid = 1'b0;

    while (words_due != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
